// File: src/oate_pkg.sv
// Shared types and constants for the ordered array table engine.
// No dependencies; every other file refers to it by scoped names.
package oate_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int POS_W       = 4;
  localparam int WORD_W      = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LINEAR = 3'd2,
    OP_BINARY = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_BSEARCH
  } state_t;

  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              load_match;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

  typedef struct packed {
    logic              eq;
    logic              lt;
    logic [WORD_W-1:0] word;
  } cell_sel_t;

endpackage

// File: src/ordered_array_table_engine.sv
// Top level of the ordered array table engine: command sequencer and cell chain.
// Depends on oate_pkg and oate_cell.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the final result of that command has been driven. Every result is on
// the outputs for one cycle with strobe high and must be captured then, since
// the block cannot be stalled. Insert, delete, read, and rejected commands are
// answered from the dispatch state. Linear search walks the match flags down the
// cell chain one index per cycle, ending early once 16 matches are held; binary
// search halves the range on each step until it finds the key or the range is empty.
module ordered_array_table_engine #(
  parameter int DEPTH = oate_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [3:0]         position,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic [3:0]         found_index,
  output logic signed [31:0] read_value,
  output logic [4:0]         fill_count,
  output logic               last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int FW = (CW > 5) ? CW : 5;
  localparam int NW = $clog2(oate_pkg::MAX_RESULTS + 1);

  oate_pkg::state_t     state, state_next;
  logic [2:0]           op_q;
  logic [3:0]           pos_q;
  logic [31:0]          word_q;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        scan_idx, scan_idx_next;
  logic [NW-1:0]        nres, nres_next;
  logic                 pend, pend_next;
  logic [CW-1:0]        pend_idx, pend_idx_next;
  logic signed [CW:0]   lo, lo_next;
  logic signed [CW:0]   hi, hi_next;

  oate_pkg::cell_ctl_t  ctl;
  logic [IW-1:0]        sel_index;
  logic [31:0]          entry_w [DEPTH];
  logic [31:0]          up_w    [DEPTH];
  logic [31:0]          down_w  [DEPTH];
  logic                 match_w [DEPTH];
  logic                 mnext_w [DEPTH];
  oate_pkg::cell_sel_t  sel_w   [DEPTH];

  logic                 sel_eq;
  logic                 sel_lt;
  logic [31:0]          sel_word;

  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        cnt_x;
  logic                 full;
  logic [CW+1:0]        mid_sum;
  logic [CW-1:0]        mid_w;

  logic                 emit;
  oate_pkg::status_t    emit_status;
  logic [CW-1:0]        emit_idx;
  logic [31:0]          emit_word;
  logic                 emit_last;
  logic [XW-1:0]        idx_x;
  logic [FW-1:0]        fill_x;

  assign busy    = state != oate_pkg::S_IDLE;
  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count);
  assign full    = count >= CW'(DEPTH);
  assign mid_sum = {lo[CW], lo} + {hi[CW], hi};
  assign mid_w   = mid_sum[CW:1];
  assign idx_x   = XW'(emit_idx);
  assign fill_x  = FW'(count_next);

  assign sel_index = (state == oate_pkg::S_BSEARCH) ? mid_w[IW-1:0] : pos_x[IW-1:0];

  always_comb begin
    up_w[0] = '0;
    for (int i = 1; i < DEPTH; i++) begin
      up_w[i] = entry_w[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      down_w[i]  = entry_w[i+1];
      mnext_w[i] = match_w[i+1];
    end
    down_w[DEPTH-1]  = '0;
    mnext_w[DEPTH-1] = 1'b0;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    oate_cell #(
      .INDEX (g),
      .IW    (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel_index (sel_index),
      .up_word   (up_w[g]),
      .down_word (down_w[g]),
      .match_in  (mnext_w[g]),
      .entry     (entry_w[g]),
      .match     (match_w[g]),
      .sel_out   (sel_w[g])
    );
  end

  always_comb begin
    sel_eq   = 1'b0;
    sel_lt   = 1'b0;
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_eq   = sel_eq | sel_w[i].eq;
      sel_lt   = sel_lt | sel_w[i].lt;
      sel_word = sel_word | sel_w[i].word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oate_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q   <= opcode;
      pos_q  <= position;
      word_q <= value;
    end
    scan_idx <= scan_idx_next;
    nres     <= nres_next;
    pend     <= pend_next;
    pend_idx <= pend_idx_next;
    lo       <= lo_next;
    hi       <= hi_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    nres_next      = nres;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    lo_next        = lo;
    hi_next        = hi;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.load_match = 1'b0;
    ctl.pos        = pos_q;
    ctl.word       = word_q;
    emit           = 1'b0;
    emit_status    = oate_pkg::ST_OK;
    emit_idx       = '0;
    emit_word      = '0;
    emit_last      = 1'b1;
    case (state)
      oate_pkg::S_IDLE: begin
        if (start) begin
          state_next = oate_pkg::S_DISPATCH;
        end
      end
      oate_pkg::S_DISPATCH: begin
        state_next = oate_pkg::S_IDLE;
        case (op_q)
          oate_pkg::OP_INSERT: begin
            emit = 1'b1;
            if (full) begin
              emit_status = oate_pkg::ST_FULL;
            end else if (pos_x > cnt_x) begin
              emit_status = oate_pkg::ST_BADPOS;
            end else begin
              ctl.shift_up = 1'b1;
              count_next   = count + CW'(1);
            end
          end
          oate_pkg::OP_DELETE: begin
            emit = 1'b1;
            if (pos_x >= cnt_x) begin
              emit_status = oate_pkg::ST_BADPOS;
            end else begin
              ctl.shift_down = 1'b1;
              count_next     = count - CW'(1);
            end
          end
          oate_pkg::OP_LINEAR: begin
            ctl.load_match = 1'b1;
            scan_idx_next  = '0;
            nres_next      = '0;
            pend_next      = 1'b0;
            state_next     = oate_pkg::S_SCAN;
          end
          oate_pkg::OP_BINARY: begin
            lo_next    = '0;
            hi_next    = $signed({1'b0, count}) - (CW+1)'(1);
            state_next = oate_pkg::S_BSEARCH;
          end
          oate_pkg::OP_READ: begin
            emit = 1'b1;
            if (pos_x >= cnt_x) begin
              emit_status = oate_pkg::ST_BADPOS;
            end else begin
              emit_word = sel_word;
            end
          end
          default: begin
            emit        = 1'b1;
            emit_status = oate_pkg::ST_BADPOS;
          end
        endcase
      end
      oate_pkg::S_SCAN: begin
        if (scan_idx == count || nres == NW'(oate_pkg::MAX_RESULTS)) begin
          emit       = 1'b1;
          state_next = oate_pkg::S_IDLE;
          if (pend) begin
            emit_idx = pend_idx;
          end else begin
            emit_status = oate_pkg::ST_NOTFOUND;
          end
        end else begin
          scan_idx_next = scan_idx + CW'(1);
          if (match_w[0]) begin
            if (pend) begin
              emit      = 1'b1;
              emit_last = 1'b0;
              emit_idx  = pend_idx;
            end
            pend_next     = 1'b1;
            pend_idx_next = scan_idx;
            nres_next     = nres + NW'(1);
          end
        end
      end
      oate_pkg::S_BSEARCH: begin
        if (lo > hi) begin
          emit        = 1'b1;
          emit_status = oate_pkg::ST_NOTFOUND;
          state_next  = oate_pkg::S_IDLE;
        end else if (sel_eq) begin
          emit       = 1'b1;
          emit_idx   = mid_w;
          state_next = oate_pkg::S_IDLE;
        end else if (sel_lt) begin
          hi_next = $signed({1'b0, mid_w}) - (CW+1)'(1);
        end else begin
          lo_next = $signed({1'b0, mid_w}) + (CW+1)'(1);
        end
      end
      default: begin
        state_next = oate_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= emit_status;
      found_index <= idx_x[3:0];
      read_value  <= emit_word;
      fill_count  <= fill_x[4:0];
      last        <= emit_last;
    end
  end

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above table depth");

  a_done_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("transaction ended without a final result");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != oate_pkg::ST_OK |-> last)
    else $error("error status on a non-final result");

endmodule

// File: src/oate_cell.sv
// One storage cell of the table chain: holds one entry and its match flag.
// Depends on oate_pkg for the control and select structs and its constants.
module oate_cell #(
  parameter int INDEX = 0,
  parameter int IW    = $clog2(oate_pkg::DEPTH_DEF)
) (
  input  logic                              clk,
  input  oate_pkg::cell_ctl_t               ctl,
  input  logic [IW-1:0]                     sel_index,
  input  logic [oate_pkg::WORD_W-1:0]       up_word,
  input  logic [oate_pkg::WORD_W-1:0]       down_word,
  input  logic                              match_in,
  output logic [oate_pkg::WORD_W-1:0]       entry,
  output logic                              match,
  output oate_pkg::cell_sel_t               sel_out
);

  logic [31:0] pos_w;
  logic        above;
  logic        at_pos;
  logic        hit;
  logic        key_eq;

  assign pos_w  = 32'(ctl.pos);
  assign above  = 32'(INDEX) > pos_w;
  assign at_pos = 32'(INDEX) == pos_w;
  assign hit    = sel_index == IW'(INDEX);
  assign key_eq = entry == ctl.word;

  always_ff @(posedge clk) begin
    if (ctl.shift_up) begin
      if (above) begin
        entry <= up_word;
      end else if (at_pos) begin
        entry <= ctl.word;
      end
    end else if (ctl.shift_down && (above || at_pos)) begin
      entry <= down_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_match) begin
      match <= key_eq;
    end else begin
      match <= match_in;
    end
  end

  always_comb begin
    sel_out.eq   = hit & key_eq;
    sel_out.lt   = hit & ($signed(ctl.word) < $signed(entry));
    sel_out.word = hit ? entry : '0;
  end

endmodule

// File: sim/tb.sv
// Testbench for ordered_array_table_engine: directed and random table commands checked
// field by field against an in-bench shadow of the word table and fill count.
// Depends on oate_pkg and the engine RTL in src.
module tb;

  localparam int DEPTH = oate_pkg::DEPTH_DEF;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int DRAIN_LIMIT = 400;

  typedef struct {
    oate_pkg::status_t  status;
    logic [3:0]         idx;
    logic signed [31:0] rd;
    logic [4:0]         fill;
    logic               fin;
  } answer_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic [3:0]         position;
  logic signed [31:0] value;
  logic               strobe;
  logic [1:0]         status;
  logic [3:0]         found_index;
  logic signed [31:0] read_value;
  logic [4:0]         fill_count;
  logic               last;

  logic signed [31:0] shadow_words [DEPTH];
  int                 shadow_fill;
  answer_t            pending_answers [$];

  int error_count;
  int commands_sent;
  int answers_checked;
  int full_rejects;
  int deepest_fill;
  int most_hits;

  ordered_array_table_engine #(.DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .position(position),
    .value(value),
    .strobe(strobe),
    .status(status),
    .found_index(found_index),
    .read_value(read_value),
    .fill_count(fill_count),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_error(input string msg);
    if (error_count < 40) begin
      $display("%0t ERROR %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic void push_answer(input oate_pkg::status_t st, input int idx,
                                      input logic signed [31:0] rd, input logic fin);
    answer_t a;
    a.status = st;
    a.idx    = idx[3:0];
    a.rd     = rd;
    a.fill   = shadow_fill[4:0];
    a.fin    = fin;
    pending_answers.push_back(a);
  endfunction

  task automatic run_table_command(input logic [2:0] op, input logic [3:0] pos,
                                   input logic signed [31:0] val);
    int   i;
    int   lo;
    int   hi;
    int   mid;
    int   n;
    int   hits [oate_pkg::MAX_RESULTS];
    logic found;
    case (op)
      oate_pkg::OP_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          push_answer(oate_pkg::ST_FULL, 0, 0, 1'b1);
          full_rejects++;
        end else if (pos > shadow_fill) begin
          push_answer(oate_pkg::ST_BADPOS, 0, 0, 1'b1);
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = val;
          shadow_fill++;
          if (shadow_fill > deepest_fill) deepest_fill = shadow_fill;
          push_answer(oate_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      oate_pkg::OP_DELETE: begin
        if (pos >= shadow_fill) begin
          push_answer(oate_pkg::ST_BADPOS, 0, 0, 1'b1);
        end else begin
          for (i = pos; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
          push_answer(oate_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      oate_pkg::OP_LINEAR: begin
        n = 0;
        for (i = 0; i < shadow_fill && n < oate_pkg::MAX_RESULTS; i++) begin
          if (shadow_words[i] == val) begin
            hits[n] = i;
            n++;
          end
        end
        if (n == 0) push_answer(oate_pkg::ST_NOTFOUND, 0, 0, 1'b1);
        for (i = 0; i < n; i++) push_answer(oate_pkg::ST_OK, hits[i], 0, i == n - 1);
        if (n > most_hits) most_hits = n;
      end
      oate_pkg::OP_BINARY: begin
        lo    = 0;
        hi    = shadow_fill - 1;
        mid   = 0;
        found = 1'b0;
        while (!found && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_words[mid] == val) found = 1'b1;
          else if (val < shadow_words[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
        if (found) push_answer(oate_pkg::ST_OK, mid, 0, 1'b1);
        else push_answer(oate_pkg::ST_NOTFOUND, 0, 0, 1'b1);
      end
      oate_pkg::OP_READ: begin
        if (pos >= shadow_fill) push_answer(oate_pkg::ST_BADPOS, 0, 0, 1'b1);
        else push_answer(oate_pkg::ST_OK, 0, shadow_words[pos], 1'b1);
      end
      default: begin
        push_answer(oate_pkg::ST_BADPOS, 0, 0, 1'b1);
      end
    endcase
  endtask

  task automatic issue_command(input logic [2:0] op, input logic [3:0] pos,
                               input logic signed [31:0] val);
    @(negedge clk);
    opcode   = op;
    position = pos;
    value    = val;
    start    = 1'b1;
    do @(posedge clk); while (busy);
    run_table_command(op, pos, val);
    commands_sent++;
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_answers();
    int waited;
    waited = 0;
    @(negedge clk);
    start = 1'b0;
    while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_answers.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived",
                             pending_answers.size()));
      pending_answers.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_answers
    answer_t e;
    if (!rst && strobe) begin
      if (pending_answers.size() == 0) begin
        report_error($sformatf("unexpected result status=%0d index=%0d", status,
                               found_index));
      end else begin
        e = pending_answers.pop_front();
        answers_checked++;
        if (status !== e.status)
          report_error($sformatf("status got %0d exp %0d", status, e.status));
        if (found_index !== e.idx)
          report_error($sformatf("found_index got %0d exp %0d", found_index, e.idx));
        if (read_value !== e.rd)
          report_error($sformatf("read_value got %0d exp %0d", read_value, e.rd));
        if (fill_count !== e.fill)
          report_error($sformatf("fill_count got %0d exp %0d", fill_count, e.fill));
        if (last !== e.fin)
          report_error($sformatf("last got %0d exp %0d", last, e.fin));
      end
    end
  end

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return WORD_MIN;
    if (r == 1) return WORD_MAX;
    if (r < 6) return $signed($urandom_range(0, 6)) - 3;
    return $urandom;
  endfunction

  task automatic test_empty_table();
    issue_command(oate_pkg::OP_INSERT, 4'd1, 32'sd9);
    issue_command(oate_pkg::OP_READ, 4'd0, 0);
    issue_command(oate_pkg::OP_DELETE, 4'd0, 0);
    issue_command(oate_pkg::OP_LINEAR, 4'd0, 0);
    issue_command(oate_pkg::OP_BINARY, 4'd15, WORD_MIN);
  endtask

  task automatic test_unused_opcodes();
    int k;
    for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) begin
      issue_command(k[2:0], 4'd15, $urandom);
    end
  endtask

  task automatic test_fill_and_full();
    int k;
    issue_command(oate_pkg::OP_INSERT, 4'd0, WORD_MAX);
    issue_command(oate_pkg::OP_INSERT, 4'd0, WORD_MIN);
    issue_command(oate_pkg::OP_INSERT, 4'd1, 32'sd0);
    issue_command(oate_pkg::OP_INSERT, 4'd1, -32'sd1);
    for (k = 0; k < DEPTH - 4; k++) issue_command(oate_pkg::OP_INSERT, 4'd3, 32'sd7);
    issue_command(oate_pkg::OP_INSERT, 4'd15, 32'sd1);
  endtask

  task automatic test_searches();
    issue_command(oate_pkg::OP_LINEAR, 4'd0, 32'sd7);
    issue_command(oate_pkg::OP_BINARY, 4'd0, 32'sd7);
    issue_command(oate_pkg::OP_BINARY, 4'd0, WORD_MAX);
    issue_command(oate_pkg::OP_BINARY, 4'd0, 32'sd3);
    issue_command(oate_pkg::OP_READ, 4'd15, 0);
  endtask

  task automatic test_delete_edges();
    issue_command(oate_pkg::OP_DELETE, 4'd15, 0);
    issue_command(oate_pkg::OP_READ, 4'd15, 0);
    issue_command(oate_pkg::OP_DELETE, 4'd0, 0);
    issue_command(oate_pkg::OP_INSERT, 4'd0, WORD_MAX);
    issue_command(oate_pkg::OP_BINARY, 4'd0, -32'sd1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                 k;
    int                 i;
    int                 r;
    int                 burst_left;
    int                 gap;
    int                 ins_weight;
    logic               growing;
    logic [2:0]         op;
    logic [3:0]         pos;
    logic signed [31:0] val;
    burst_left = 0;
    growing    = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) idle_cycles(gap);
        if ($urandom_range(0, 2) == 0) growing = ~growing;
      end
      burst_left--;
      if ($urandom_range(0, 39) == 0) drain_answers();
      ins_weight = growing ? 55 : 15;
      pos = 4'($urandom_range(0, 15));
      val = pick_word();
      if ($urandom_range(0, 99) < ins_weight) begin
        op = oate_pkg::OP_INSERT;
        r  = $urandom_range(0, 9);
        if (r < 6) begin
          i = 0;
          while (i < shadow_fill && shadow_words[i] < val) i++;
          pos = 4'(i);
        end else if (r < 9) begin
          pos = 4'($urandom_range(0, shadow_fill));
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) op = oate_pkg::OP_DELETE;
        else if (r < 45) op = oate_pkg::OP_LINEAR;
        else if (r < 65) op = oate_pkg::OP_BINARY;
        else if (r < 90) op = oate_pkg::OP_READ;
        else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        if ((op == oate_pkg::OP_DELETE || op == oate_pkg::OP_READ) && shadow_fill > 0 &&
            $urandom_range(0, 7) != 0)
          pos = 4'($urandom_range(0, shadow_fill - 1));
        if ((op == oate_pkg::OP_LINEAR || op == oate_pkg::OP_BINARY) && shadow_fill > 0 &&
            $urandom_range(0, 2) != 0)
          val = shadow_words[$urandom_range(0, shadow_fill - 1)];
      end
      issue_command(op, pos, val);
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    opcode          = '0;
    position        = '0;
    value           = '0;
    shadow_fill     = 0;
    error_count     = 0;
    commands_sent   = 0;
    answers_checked = 0;
    full_rejects    = 0;
    deepest_fill    = 0;
    most_hits       = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_unused_opcodes();
    test_fill_and_full();
    test_searches();
    test_delete_edges();
    drain_answers();
    test_random_traffic(125);
    drain_answers();
    test_random_traffic(125);
    drain_answers();

    $display("Covered %0d commands with %0d results checked; %0d full-table rejects,",
             commands_sent, answers_checked, full_rejects);
    $display("deepest fill %0d, longest linear match run %0d", deepest_fill, most_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
